>>> src/free_range_allocator_macros.svh
// Assertion helpers for the free range allocator
`ifndef FREE_RANGE_ALLOCATOR_MACROS_SVH
`define FREE_RANGE_ALLOCATOR_MACROS_SVH

// Check a property on every clock edge outside reset
`define FRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define FRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/fra_pkg.sv
package fra_pkg;

  // Default sizing
  localparam int unsigned MAX_RANGES_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF  = 32;

  // Fixed port field widths
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned IN_W     = 104;
  localparam int unsigned OUT_W    = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_MERGE = 2'd0,
    CMD_RESERVE   = 2'd1,
    CMD_ADD_PLAIN = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    RS_OK       = 3'd0,
    RS_OVERFLOW = 3'd1,
    RS_DUP      = 3'd2,
    RS_NOFIT    = 3'd3,
    RS_FULL     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_RD,
    FS_EV,
    FS_DIV,
    FS_CHK,
    FS_DECIDE,
    FS_DRD,
    FS_DEV,
    FS_RPLAN,
    FS_W1,
    FS_OP2,
    FS_MVWR,
    FS_RESP
  } fsm_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_APPEND,
    OP_REMOVE
  } op2_e;

endpackage

>>> src/fra_ram.sv
module fra_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/fra_rem.sv
module fra_rem #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned NW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvd_q, dvd_d;
  logic [W-1:0]  dsr_q, dsr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    trial;

  // Restoring division, one quotient bit per cycle; only the remainder is kept
  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[W-1]};
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = NW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = W'(trial);
      end
      dvd_d = {dvd_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> src/free_range_allocator.sv
// Channel  | Dir | Handshake               | Payload
// s_axis   | in  | s_axis_tvalid/tready    | command, range_base, length, alignment
// m_axis   | out | m_axis_tvalid/tready    | status, granted_address
//
// One command at a time. The free list sits packed in entries 0..count-1 of one
// RAM; a scan reads the entries one at a time through the registered read port.
// A reserve checks the alignment of each candidate entry, through the
// remainder unit when the alignment is not a power of two, and runs a second
// scan when a trailing fragment is left. No clearing pass is needed after reset.
// A waiting result stalls only the next command's result, not its acceptance.
module free_range_allocator #(
  parameter int unsigned MAX_RANGES = fra_pkg::MAX_RANGES_DEF,
  parameter int unsigned ADDR_BITS  = fra_pkg::ADDR_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [1:0] command, [33:2] range_base, [65:34] length, [97:66] alignment
  input  logic [fra_pkg::IN_W-1:0] s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // [2:0] status, [34:3] granted_address
  output logic [fra_pkg::OUT_W-1:0] m_axis_tdata_o
);

  import fra_pkg::*;

  `include "free_range_allocator_macros.svh"

  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned IW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned DW = 2 * AW;

  // Field decode
  logic [AW-1:0] in_base, in_len, in_align;
  cmd_e          in_cmd;
  logic [AW:0]   in_sum;

  assign in_cmd   = cmd_e'(s_axis_tdata_i[1:0]);
  assign in_base  = AW'(s_axis_tdata_i[33:2]);
  assign in_len   = AW'(s_axis_tdata_i[65:34]);
  assign in_align = AW'(s_axis_tdata_i[97:66]);
  assign in_sum   = {1'b0, in_base} + {1'b0, in_len};

  fsm_e          state_q, state_d;
  cmd_e          cmd_q, cmd_d;
  logic [AW-1:0] base_q, base_d, len_q, len_d, align_q, align_d;
  logic          pow2_q, pow2_d;
  logic [CW-1:0] idx_q, idx_d, cnt_q, cnt_d;

  logic          li_ok_q, li_ok_d, ri_ok_q, ri_ok_d, dup_q, dup_d;
  logic [IW-1:0] li_idx_q, li_idx_d, ri_idx_q, ri_idx_d;
  logic [AW-1:0] li_s_q, li_s_d, li_len_q, li_len_d, ri_s_q, ri_s_d, ri_len_q, ri_len_d;

  logic          best_ok_q, best_ok_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [AW-1:0] best_s_q, best_s_d, best_len_q, best_len_d, best_at_q, best_at_d;
  logic [AW-1:0] cur_s_q, cur_s_d, cur_len_q, cur_len_d, rem_q, rem_d;

  logic          w1_en_q, w1_en_d;
  logic [IW-1:0] w1_idx_q, w1_idx_d, op2_idx_q, op2_idx_d;
  logic [DW-1:0] w1_data_q, w1_data_d, op2_data_q, op2_data_d;
  op2_e          op2_q, op2_d;

  status_e       res_st_q, res_st_d, out_st_q, out_st_d;
  logic [AW-1:0] res_gr_q, res_gr_d, out_gr_q, out_gr_d;
  logic          m_valid_q, m_valid_d;

  // RAM and remainder unit hookup
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0] rd_s, rd_len;
  logic          div_start, div_done;
  logic [AW-1:0] div_rem;

  fra_ram #(.WIDTH(DW), .DEPTH(MAX_RANGES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The dividend is taken at start, while the candidate's start is on the read port
  fra_rem #(.W(AW)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_s),
    .divisor_i  (align_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign rd_s   = ram_rdata[AW-1:0];
  assign rd_len = ram_rdata[DW-1:AW];

  // Scan stepping
  logic [CW-1:0] idx_nxt, cnt_m1;
  logic          scan_end;
  assign idx_nxt  = idx_q + 1'b1;
  assign scan_end = (idx_nxt == cnt_q);
  assign cnt_m1   = cnt_q - 1'b1;

  // Alignment check of the held candidate
  logic [AW-1:0] add_v, at_v, off_v;
  logic [AW:0]   sum_w;
  logic          wrap, fit;
  assign add_v = align_q - rem_q;
  assign sum_w = {1'b0, cur_s_q} + {1'b0, add_v};
  assign wrap  = (rem_q != '0) && sum_w[AW];
  assign at_v  = (rem_q == '0) ? cur_s_q : sum_w[AW-1:0];
  assign off_v = (rem_q == '0) ? '0 : add_v;
  assign fit   = !wrap && (off_v <= cur_len_q) && ((cur_len_q - off_v) >= len_q);

  // Merge plan
  logic          ml, mr;
  logic [AW-1:0] end_a, nstart, nend;
  logic [CW:0]   after_m, after_r;
  assign end_a   = base_q + len_q;
  assign ml      = li_ok_q && ((li_s_q + li_len_q) == base_q);
  assign mr      = ri_ok_q && (ri_s_q == end_a);
  assign nstart  = ml ? li_s_q : base_q;
  assign nend    = mr ? (ri_s_q + ri_len_q) : end_a;
  assign after_m = (CW+1)'(cnt_q) + 1'b1 - (CW+1)'(ml) - (CW+1)'(mr);

  // Reserve split
  logic [AW-1:0] aend, llen, rlen;
  assign aend    = best_at_q + len_q;
  assign llen    = best_at_q - best_s_q;
  assign rlen    = best_s_q + best_len_q - aend;
  assign after_r = (CW+1)'(cnt_q) - 1'b1 + (CW+1)'(llen != '0) + (CW+1)'(rlen != '0);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    base_d     = base_q;
    len_d      = len_q;
    align_d    = align_q;
    pow2_d     = pow2_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    li_ok_d    = li_ok_q;
    li_idx_d   = li_idx_q;
    li_s_d     = li_s_q;
    li_len_d   = li_len_q;
    ri_ok_d    = ri_ok_q;
    ri_idx_d   = ri_idx_q;
    ri_s_d     = ri_s_q;
    ri_len_d   = ri_len_q;
    dup_d      = dup_q;
    best_ok_d  = best_ok_q;
    best_idx_d = best_idx_q;
    best_s_d   = best_s_q;
    best_len_d = best_len_q;
    best_at_d  = best_at_q;
    cur_s_d    = cur_s_q;
    cur_len_d  = cur_len_q;
    rem_d      = rem_q;
    w1_en_d    = w1_en_q;
    w1_idx_d   = w1_idx_q;
    w1_data_d  = w1_data_q;
    op2_d      = op2_q;
    op2_idx_d  = op2_idx_q;
    op2_data_d = op2_data_q;
    res_st_d   = res_st_q;
    res_gr_d   = res_gr_q;
    out_st_d   = out_st_q;
    out_gr_d   = out_gr_q;
    m_valid_d  = m_valid_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = idx_q[IW-1:0];
    div_start  = 1'b0;
    s_axis_tready_o = (state_q == FS_IDLE);

    // Release the output register
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      FS_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d     = in_cmd;
          base_d    = in_base;
          len_d     = in_len;
          align_d   = (in_align == '0) ? AW'(1) : in_align;
          pow2_d    = ((in_align & (in_align - 1'b1)) == '0);
          idx_d     = '0;
          li_ok_d   = 1'b0;
          ri_ok_d   = 1'b0;
          dup_d     = 1'b0;
          best_ok_d = 1'b0;
          w1_en_d   = 1'b0;
          op2_d     = OP_NONE;
          res_st_d  = RS_OK;
          res_gr_d  = '0;
          if (in_cmd == CMD_NOP || in_len == '0) begin
            state_d = FS_RESP;
          end else if (in_cmd != CMD_RESERVE && in_sum[AW]) begin
            res_st_d = RS_OVERFLOW;
            state_d  = FS_RESP;
          end else if (cnt_q == '0) begin
            state_d = FS_DECIDE;
          end else begin
            state_d = FS_RD;
          end
        end
      end
      FS_RD: begin
        ram_re  = 1'b1;
        state_d = FS_EV;
      end
      FS_EV: begin
        idx_d   = idx_nxt;
        state_d = scan_end ? FS_DECIDE : FS_RD;
        if (cmd_q == CMD_RESERVE) begin
          cur_s_d   = rd_s;
          cur_len_d = rd_len;
          if (!(rd_len < len_q || (best_ok_q && rd_s >= best_s_q))) begin
            // Candidate: hold the scan until its remainder is known
            idx_d = idx_q;
            if (pow2_q) begin
              rem_d   = rd_s & (align_q - 1'b1);
              state_d = FS_CHK;
            end else begin
              div_start = 1'b1;
              state_d   = FS_DIV;
            end
          end
        end else begin
          if (rd_s < base_q && (!li_ok_q || rd_s > li_s_q)) begin
            li_ok_d  = 1'b1;
            li_idx_d = idx_q[IW-1:0];
            li_s_d   = rd_s;
            li_len_d = rd_len;
          end
          if (rd_s > base_q && (!ri_ok_q || rd_s < ri_s_q)) begin
            ri_ok_d  = 1'b1;
            ri_idx_d = idx_q[IW-1:0];
            ri_s_d   = rd_s;
            ri_len_d = rd_len;
          end
          if (rd_s == base_q) begin
            dup_d = 1'b1;
          end
        end
      end
      FS_DIV: begin
        if (div_done) begin
          rem_d   = div_rem;
          state_d = FS_CHK;
        end
      end
      FS_CHK: begin
        if (fit) begin
          best_ok_d  = 1'b1;
          best_idx_d = idx_q[IW-1:0];
          best_s_d   = cur_s_q;
          best_len_d = cur_len_q;
          best_at_d  = at_v;
        end
        idx_d   = idx_nxt;
        state_d = scan_end ? FS_DECIDE : FS_RD;
      end
      FS_DECIDE: begin
        case (cmd_q)
          CMD_ADD_PLAIN: begin
            if (dup_q) begin
              res_st_d = RS_DUP;
              state_d  = FS_RESP;
            end else if (cnt_q >= CW'(MAX_RANGES)) begin
              res_st_d = RS_FULL;
              state_d  = FS_RESP;
            end else begin
              op2_d      = OP_APPEND;
              op2_data_d = {len_q, base_q};
              state_d    = FS_OP2;
            end
          end
          CMD_ADD_MERGE: begin
            if (!ml && dup_q) begin
              res_st_d = RS_DUP;
              state_d  = FS_RESP;
            end else if (after_m > (CW+1)'(MAX_RANGES)) begin
              res_st_d = RS_FULL;
              state_d  = FS_RESP;
            end else begin
              if (ml) begin
                w1_en_d   = 1'b1;
                w1_idx_d  = li_idx_q;
                w1_data_d = {nend - nstart, nstart};
                if (mr) begin
                  op2_d     = OP_REMOVE;
                  op2_idx_d = ri_idx_q;
                end
              end else if (mr) begin
                w1_en_d   = 1'b1;
                w1_idx_d  = ri_idx_q;
                w1_data_d = {nend - nstart, nstart};
              end else begin
                op2_d      = OP_APPEND;
                op2_data_d = {nend - nstart, nstart};
              end
              state_d = w1_en_d ? FS_W1 : FS_OP2;
            end
          end
          default: begin
            if (!best_ok_q) begin
              res_st_d = RS_NOFIT;
              state_d  = FS_RESP;
            end else if (rlen != '0) begin
              idx_d   = '0;
              state_d = FS_DRD;
            end else begin
              state_d = FS_RPLAN;
            end
          end
        endcase
      end
      FS_DRD: begin
        ram_re  = 1'b1;
        state_d = FS_DEV;
      end
      FS_DEV: begin
        if (idx_q[IW-1:0] != best_idx_q && rd_s == aend) begin
          dup_d = 1'b1;
        end
        idx_d   = idx_nxt;
        state_d = scan_end ? FS_RPLAN : FS_DRD;
      end
      FS_RPLAN: begin
        if (rlen != '0 && dup_q) begin
          res_st_d = RS_DUP;
          state_d  = FS_RESP;
        end else if (after_r > (CW+1)'(MAX_RANGES)) begin
          res_st_d = RS_FULL;
          state_d  = FS_RESP;
        end else begin
          res_gr_d = best_at_q;
          if (llen != '0) begin
            w1_en_d   = 1'b1;
            w1_idx_d  = best_idx_q;
            w1_data_d = {llen, best_s_q};
            if (rlen != '0) begin
              op2_d      = OP_APPEND;
              op2_data_d = {rlen, aend};
            end
          end else if (rlen != '0) begin
            w1_en_d   = 1'b1;
            w1_idx_d  = best_idx_q;
            w1_data_d = {rlen, aend};
          end else begin
            op2_d     = OP_REMOVE;
            op2_idx_d = best_idx_q;
          end
          state_d = w1_en_d ? FS_W1 : FS_OP2;
        end
      end
      FS_W1: begin
        ram_we    = 1'b1;
        ram_waddr = w1_idx_q;
        ram_wdata = w1_data_q;
        state_d   = FS_OP2;
      end
      FS_OP2: begin
        state_d = FS_RESP;
        case (op2_q)
          OP_APPEND: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_q[IW-1:0];
            ram_wdata = op2_data_q;
            cnt_d     = cnt_q + 1'b1;
          end
          OP_REMOVE: begin
            if (op2_idx_q == cnt_m1[IW-1:0]) begin
              cnt_d = cnt_m1;
            end else begin
              // Fetch the last entry to fill the hole
              ram_re    = 1'b1;
              ram_raddr = cnt_m1[IW-1:0];
              state_d   = FS_MVWR;
            end
          end
          default: begin
          end
        endcase
      end
      FS_MVWR: begin
        ram_we    = 1'b1;
        ram_waddr = op2_idx_q;
        ram_wdata = ram_rdata;
        cnt_d     = cnt_m1;
        state_d   = FS_RESP;
      end
      FS_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          out_st_d  = res_st_q;
          out_gr_d  = res_gr_q;
          state_d   = FS_IDLE;
        end
      end
      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FS_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    base_q     <= base_d;
    len_q      <= len_d;
    align_q    <= align_d;
    pow2_q     <= pow2_d;
    idx_q      <= idx_d;
    li_ok_q    <= li_ok_d;
    li_idx_q   <= li_idx_d;
    li_s_q     <= li_s_d;
    li_len_q   <= li_len_d;
    ri_ok_q    <= ri_ok_d;
    ri_idx_q   <= ri_idx_d;
    ri_s_q     <= ri_s_d;
    ri_len_q   <= ri_len_d;
    dup_q      <= dup_d;
    best_ok_q  <= best_ok_d;
    best_idx_q <= best_idx_d;
    best_s_q   <= best_s_d;
    best_len_q <= best_len_d;
    best_at_q  <= best_at_d;
    cur_s_q    <= cur_s_d;
    cur_len_q  <= cur_len_d;
    rem_q      <= rem_d;
    w1_en_q    <= w1_en_d;
    w1_idx_q   <= w1_idx_d;
    w1_data_q  <= w1_data_d;
    op2_q      <= op2_d;
    op2_idx_q  <= op2_idx_d;
    op2_data_q <= op2_data_d;
    res_st_q   <= res_st_d;
    res_gr_q   <= res_gr_d;
    out_st_q   <= out_st_d;
    out_gr_q   <= out_gr_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'b0, 32'(out_gr_q), out_st_q};

  // Short names for the checks below
  logic in_fire, cnt_wb;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_wb  = (state_q == FS_OP2) || (state_q == FS_MVWR);

  `FRA_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(MAX_RANGES), "entry count above table size")
  `FRA_ASSERT(a_accept_busy, in_fire |=> state_q != FS_IDLE, "item accepted, sequencer idle")
  `FRA_ASSERT(a_cnt_change, !$stable(cnt_q) |-> $past(cnt_wb), "count moved outside write-back")
  `FRA_ASSERT(a_div_done, div_done |-> state_q == FS_DIV, "remainder finished outside wait state")

endmodule

>>> dv/tb_free_range_allocator.sv
module tb_free_range_allocator;
  import fra_pkg::*;

  localparam longint unsigned ADDR_MASK = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned     TABLE_DEPTH = 64;

  // Holds the free-range table, predicts each command and checks its result
  class alloc_scoreboard;
    longint unsigned free_start[$];
    longint unsigned free_len[$];
    status_e         want_status[$];
    logic [31:0]     want_addr[$];
    int              mismatches;
    int              results_seen;
    int              cmd_seen[4];
    int              status_seen[5];

    function int pending();
      return want_status.size();
    endfunction

    function void drop_two(int a, int b);
      int hi, lo;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      if (hi >= 0) begin
        free_start.delete(hi);
        free_len.delete(hi);
      end
      if (lo >= 0 && lo != hi) begin
        free_start.delete(lo);
        free_len.delete(lo);
      end
    endfunction

    function status_e merge_add(longint unsigned b, longint unsigned l);
      int li, ri, di, after;
      bit ml, mr;
      longint unsigned span_end, nstart, nend;
      li = -1;
      ri = -1;
      di = -1;
      if (l == 0) return RS_OK;
      if (l > ADDR_MASK - b) return RS_OVERFLOW;
      span_end = b + l;
      // Find nearest lower and upper neighbors and any entry at the same start
      foreach (free_start[i]) begin
        if (free_start[i] < b && (li < 0 || free_start[i] > free_start[li])) li = i;
        if (free_start[i] > b && (ri < 0 || free_start[i] < free_start[ri])) ri = i;
        if (free_start[i] == b) di = i;
      end
      ml = li >= 0 && free_start[li] + free_len[li] == b;
      mr = ri >= 0 && free_start[ri] == span_end;
      nstart = ml ? free_start[li] : b;
      nend = mr ? free_start[ri] + free_len[ri] : span_end;
      if (!ml && di >= 0) return RS_DUP;
      after = free_start.size() + 1 - int'(ml) - int'(mr);
      if (after > TABLE_DEPTH) return RS_FULL;
      drop_two(ml ? li : -1, mr ? ri : -1);
      free_start.push_back(nstart);
      free_len.push_back(nend - nstart);
      return RS_OK;
    endfunction

    function status_e plain_add(longint unsigned b, longint unsigned l);
      if (l == 0) return RS_OK;
      if (l > ADDR_MASK - b) return RS_OVERFLOW;
      foreach (free_start[i]) if (free_start[i] == b) return RS_DUP;
      if (free_start.size() >= TABLE_DEPTH) return RS_FULL;
      free_start.push_back(b);
      free_len.push_back(l);
      return RS_OK;
    endfunction

    function status_e take_block(longint unsigned sz, longint unsigned al,
                                 output longint unsigned grant);
      int best, after;
      longint unsigned best_at, s, len, rem, at, aend, llen, rlen;
      best = -1;
      best_at = 0;
      grant = 0;
      if (sz == 0) return RS_OK;
      if (al == 0) al = 1;
      // First fit by lowest start, skipping ranges whose rounded start wraps
      foreach (free_start[i]) begin
        s = free_start[i];
        len = free_len[i];
        rem = s % al;
        if (rem == 0) begin
          at = s;
        end else begin
          if (al - rem > ADDR_MASK - s) continue;
          at = s + (al - rem);
        end
        if (at - s > len || len - (at - s) < sz) continue;
        if (best < 0 || s < free_start[best]) begin
          best = i;
          best_at = at;
        end
      end
      if (best < 0) return RS_NOFIT;
      s = free_start[best];
      len = free_len[best];
      aend = best_at + sz;
      llen = best_at - s;
      rlen = s + len - aend;
      if (rlen != 0)
        foreach (free_start[i])
          if (i != best && free_start[i] == aend) return RS_DUP;
      after = free_start.size() - 1 + int'(llen != 0) + int'(rlen != 0);
      if (after > TABLE_DEPTH) return RS_FULL;
      drop_two(best, -1);
      if (llen != 0) begin
        free_start.push_back(s);
        free_len.push_back(llen);
      end
      if (rlen != 0) begin
        free_start.push_back(aend);
        free_len.push_back(rlen);
      end
      grant = best_at;
      return RS_OK;
    endfunction

    // Note an accepted command and queue its expected result
    function void note_command(cmd_e c, logic [31:0] b, logic [31:0] l, logic [31:0] a);
      status_e st;
      longint unsigned g;
      g = 0;
      st = RS_OK;
      case (c)
        CMD_ADD_MERGE: st = merge_add(b, l);
        CMD_RESERVE:   st = take_block(l, a, g);
        CMD_ADD_PLAIN: st = plain_add(b, l);
        default:       st = RS_OK;
      endcase
      cmd_seen[c]++;
      status_seen[st]++;
      want_status.push_back(st);
      want_addr.push_back(g[31:0]);
    endfunction

    // Compare one result against the oldest expectation
    function void check_result(logic [2:0] st, logic [31:0] g);
      status_e es;
      logic [31:0] ea;
      results_seen++;
      if (want_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d addr %h", st, g);
        return;
      end
      es = want_status.pop_front();
      ea = want_addr.pop_front();
      if (st !== es || g !== ea) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: status exp %0d got %0d, addr exp %h got %h",
                   results_seen, es, st, ea, g);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [IN_W-1:0]     s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OUT_W-1:0]    m_axis_tdata_o;

  alloc_scoreboard sb;
  bit idle_on;
  int hold_left;
  int rx_burst;

  free_range_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Drive result ready: long hold-off first, then always ready, or random stall bursts with idling on
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!idle_on) begin
      m_axis_tready_i <= 1'b1;
    end else if (rx_burst > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_burst <= rx_burst - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_axis_tready_i <= 1'b0;
      rx_burst <= $urandom_range(0, 16);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Check each result in the stable half of the cycle
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o[2:0], m_axis_tdata_o[34:3]);
  end

  // Offer one item, optionally after an idle burst; return at the accepting edge
  task automatic send_item(cmd_e c, logic [31:0] b, logic [31:0] l, logic [31:0] a);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, a, l, b, c};
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    sb.note_command(c, b, l, a);
    @(posedge clk_i);
  endtask

  // Build one random command, mostly well formed inside a small address window
  task automatic send_random();
    int pick;
    logic [31:0] b, l, a;
    pick = $urandom_range(0, 99);
    b = $urandom_range(0, 511) * 16;
    l = $urandom_range(1, 24) * 16;
    case ($urandom_range(0, 5))
      0: a = 0;
      1, 2: a = 32'd1 << $urandom_range(0, 12);
      3: a = $urandom_range(3, 200);
      4: a = 32'd1 << $urandom_range(13, 31);
      default: a = $urandom;
    endcase
    if (pick < 35) begin
      send_item(CMD_ADD_MERGE, b, l, a);
    end else if (pick < 55) begin
      send_item(CMD_ADD_PLAIN, b, l, a);
    end else if (pick < 88) begin
      send_item(CMD_RESERVE, $urandom, $urandom_range(1, 300), a);
    end else if (pick < 94) begin
      // Near the top of the address space: overflow and alignment wrap
      b = 32'hFFFF_FFFF - $urandom_range(0, 4095);
      send_item(cmd_e'($urandom_range(0, 3)), b, $urandom_range(0, 8192), a);
    end else begin
      send_item(cmd_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    idle_on = 1'b0;
    hold_left = 0;
    rx_burst = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero lengths, overflow edges, duplicates, joins, alignment corners
    send_item(CMD_ADD_MERGE, 32'h0000_1000, 32'h0, 32'h0);
    send_item(CMD_ADD_PLAIN, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_item(CMD_RESERVE, 32'h0, 32'h0, 32'h0);
    send_item(CMD_RESERVE, 32'h0, 32'h10, 32'h0);
    send_item(CMD_ADD_MERGE, 32'hFFFF_FFFF, 32'h2, 32'h0);
    send_item(CMD_ADD_PLAIN, 32'hFFFF_FFF0, 32'h10, 32'h0);
    send_item(CMD_ADD_PLAIN, 32'hFFFF_FFF0, 32'hF, 32'h0);
    send_item(CMD_RESERVE, 32'h0, 32'h1, 32'hFFFF_FFFF);
    send_item(CMD_ADD_PLAIN, 32'h0000_1000, 32'h100, 32'h0);
    send_item(CMD_ADD_PLAIN, 32'h0000_1000, 32'h40, 32'h0);
    send_item(CMD_ADD_MERGE, 32'h0000_1000, 32'h40, 32'h0);
    send_item(CMD_ADD_MERGE, 32'h0000_1100, 32'h100, 32'h0);
    send_item(CMD_ADD_MERGE, 32'h0000_0F00, 32'h100, 32'h0);
    send_item(CMD_ADD_MERGE, 32'h0000_0E00, 32'h80, 32'h0);
    send_item(CMD_ADD_MERGE, 32'h0000_0E80, 32'h80, 32'h0);
    send_item(CMD_RESERVE, 32'h0, 32'h20, 32'h40);
    send_item(CMD_RESERVE, 32'h0, 32'h5, 32'h3);
    send_item(CMD_ADD_PLAIN, 32'h0000_0E60, 32'h10, 32'h0);
    send_item(CMD_RESERVE, 32'h0, 32'h1B, 32'h1);
    send_item(CMD_RESERVE, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_RESERVE, 32'hFFFF_FFFF, 32'h100, 32'h8000_0000);

    // Random with idling on both sides
    idle_on = 1'b1;
    repeat (600) send_random();

    // Let every result come back before going on
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    @(posedge clk_i);

    // Long receiver hold-off while commands keep coming
    hold_left = 3000;
    repeat (100) send_random();
    repeat (400) send_random();

    // Closing stretch at full rate
    idle_on = 1'b0;
    repeat (200) send_random();
    s_axis_tvalid_i <= 1'b0;

    wait_drained();
    repeat (3000) @(posedge clk_i);
    $display("commands: merge %0d, reserve %0d, plain %0d, nop %0d",
             sb.cmd_seen[CMD_ADD_MERGE], sb.cmd_seen[CMD_RESERVE],
             sb.cmd_seen[CMD_ADD_PLAIN], sb.cmd_seen[CMD_NOP]);
    $display("outcomes: ok %0d, overflow %0d, dup %0d, no fit %0d, full %0d; %0d mismatches",
             sb.status_seen[RS_OK], sb.status_seen[RS_OVERFLOW], sb.status_seen[RS_DUP],
             sb.status_seen[RS_NOFIT], sb.status_seen[RS_FULL], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_free_range_allocator: clean");
    end else begin
      $display("tb_free_range_allocator: errors");
    end
    $finish;
  end

  // Guard against a hung run
  initial begin
    #40000000;
    $display("tb_free_range_allocator: errors");
    $finish;
  end

endmodule
